>>> design/nmea_rmc_sentence_parser_top_assert.svh
// Assertion macros for the NMEA RMC sentence parser.
// Included by nmea_rmc_sentence_parser_top; no other dependencies.
`ifndef NMEA_RMC_SENTENCE_PARSER_TOP_ASSERT_SVH
`define NMEA_RMC_SENTENCE_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset
`define NRMC_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("nrmc assertion failed");
// Consequent must hold whenever the antecedent holds
`define NRMC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("nrmc assertion failed");
`else
`define NRMC_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define NRMC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> design/nrmc_pkg.sv
// Shared types, constants and decode tables of the NMEA RMC sentence parser.
// No dependencies; used by nrmc_parse, nrmc_commit and the top level.
package nrmc_pkg;

  // Field layout limits
  localparam int unsigned FIELD_CHARS        = 32;
  localparam int unsigned MINUTE_FRAC_DIGITS = 4;
  localparam int unsigned LAT_DEG_DIGITS     = 2;
  localparam int unsigned LON_DEG_DIGITS     = 3;
  localparam int unsigned TIME_FRAC_DIGITS   = 2;

  // Saturation limits
  localparam logic [29:0] ACC_CAP  = 30'h3FFF_FFFF;
  localparam logic [48:0] TIME_MAX = 49'd99999999;
  localparam logic [48:0] LAT_MAX  = 49'd999999999;
  localparam logic [48:0] LON_MAX  = 49'd9999999999;
  localparam logic [29:0] DATE_MAX = 30'd999999;

  // Arithmetic constants: divide by three via reciprocal, degree scale 1e7
  localparam logic [31:0] RECIP3    = 32'hAAAA_AAAB;
  localparam logic [23:0] DEG_SCALE = 24'd10000000;

  // Characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_W     = 8'h57;

  // Sentence headers, first character in the top byte
  localparam logic [47:0] HDR_TXT = 48'h2447_5054_5854;
  localparam logic [47:0] HDR_RMC = 48'h2447_5052_4D43;
  localparam logic [47:0] HDR_VTG = 48'h2447_5056_5447;
  localparam logic [47:0] HDR_GGA = 48'h2447_5047_4741;
  localparam logic [47:0] HDR_GSA = 48'h2447_5047_5341;
  localparam logic [47:0] HDR_GSV = 48'h2447_5047_5356;
  localparam logic [47:0] HDR_GLL = 48'h2447_5047_4C4C;
  localparam logic [2:0]  HDR_LEN = 3'd6;

  // RMC field numbers
  localparam logic [4:0] FLD_TIME   = 5'd1;
  localparam logic [4:0] FLD_STATUS = 5'd2;
  localparam logic [4:0] FLD_LAT    = 5'd3;
  localparam logic [4:0] FLD_NS     = 5'd4;
  localparam logic [4:0] FLD_LON    = 5'd5;
  localparam logic [4:0] FLD_EW     = 5'd6;
  localparam logic [4:0] FLD_DATE   = 5'd9;
  localparam logic [4:0] FLD_LAST   = 5'd31;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0,
    KIND_TXT     = 3'd1,
    KIND_RMC     = 3'd2,
    KIND_VTG     = 3'd3,
    KIND_GGA     = 3'd4,
    KIND_GSA     = 3'd5,
    KIND_GSV     = 3'd6,
    KIND_GLL     = 3'd7
  } kind_e;

  // Snapshot of one field handed from the byte parser to the commit pipeline
  typedef struct packed {
    logic [4:0]  fnum;
    logic [29:0] acc;
    logic [9:0]  deg;
    logic [2:0]  frac;
    logic        val_seen;
    logic        deg_seen;
    logic        commit;   // line is RMC, so the field updates the stored values
    logic        eol;      // line end: emit a result after the commit
    kind_e       kind;
  } token_t;

  // Classify a line by its header
  function automatic kind_e kind_of(input logic [47:0] hdr, input logic [2:0] cnt);
    kind_e k;
    k = KIND_UNKNOWN;
    if (cnt == HDR_LEN) begin
      unique case (hdr)
        HDR_TXT: k = KIND_TXT;
        HDR_RMC: k = KIND_RMC;
        HDR_VTG: k = KIND_VTG;
        HDR_GGA: k = KIND_GGA;
        HDR_GSA: k = KIND_GSA;
        HDR_GSV: k = KIND_GSV;
        HDR_GLL: k = KIND_GLL;
        default: k = KIND_UNKNOWN;
      endcase
    end
    return k;
  endfunction

  // Time scale 10^(2 - frac)
  function automatic logic [18:0] time_scale(input logic [2:0] frac);
    logic [18:0] s;
    unique case (frac)
      3'd0:    s = 19'd100;
      3'd1:    s = 19'd10;
      default: s = 19'd1;
    endcase
    return s;
  endfunction

  // Position scale K = 5 * 10^(5 - frac); minutes*10^(7-frac)/60 = acc*K/3
  function automatic logic [18:0] pos_scale(input logic [2:0] frac);
    logic [18:0] s;
    unique case (frac)
      3'd0:    s = 19'd500000;
      3'd1:    s = 19'd50000;
      3'd2:    s = 19'd5000;
      3'd3:    s = 19'd500;
      3'd4:    s = 19'd50;
      default: s = 19'd5;
    endcase
    return s;
  endfunction

  // floor(r * K / 3) for the remainder r of acc / 3
  function automatic logic [18:0] pos_rem(input logic [1:0] r, input logic [2:0] frac);
    logic [18:0] one;
    logic [18:0] two;
    unique case (frac)
      3'd0:    begin one = 19'd166666; two = 19'd333333; end
      3'd1:    begin one = 19'd16666;  two = 19'd33333;  end
      3'd2:    begin one = 19'd1666;   two = 19'd3333;   end
      3'd3:    begin one = 19'd166;    two = 19'd333;    end
      3'd4:    begin one = 19'd16;     two = 19'd33;     end
      default: begin one = 19'd1;      two = 19'd3;      end
    endcase
    return (r == 2'd1) ? one : ((r == 2'd2) ? two : 19'd0);
  endfunction

endpackage

>>> design/nrmc_parse.sv
// Byte parser: header capture, field split and per-field decimal accumulation.
// Depends on nrmc_pkg; emits one token per comma of an RMC line and per line end.
module nrmc_parse (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      char_i,
  output logic            tok_valid_o,
  output nrmc_pkg::token_t tok_o
);

  logic [47:0] hdr_q, hdr_d;
  logic [2:0]  cil_q, cil_d;
  logic [4:0]  fnum_q, fnum_d;
  logic [5:0]  cif_q, cif_d;
  logic [29:0] acc_q, acc_d;
  logic [9:0]  deg_q, deg_d;
  logic [2:0]  frac_q, frac_d;
  logic        vseen_q, vseen_d;
  logic        vstop_q, vstop_d;
  logic        infrac_q, infrac_d;
  logic        dseen_q, dseen_d;
  logic        dstop_q, dstop_d;

  logic        is_eol, is_comma, is_digit, is_rmc;
  logic [3:0]  dig;
  logic [33:0] acc_x10;
  logic [29:0] acc_next;
  logic [12:0] deg_x10;
  logic        use_deg, use_val, use_chr;
  logic [2:0]  vmax;

  // Classify the byte and prepare the accumulator steps
  always_comb begin
    is_eol   = (char_i == nrmc_pkg::CH_LF) || (char_i == nrmc_pkg::CH_NUL);
    is_comma = (char_i == nrmc_pkg::CH_COMMA);
    is_digit = (char_i >= nrmc_pkg::CH_ZERO) && (char_i <= nrmc_pkg::CH_NINE);
    is_rmc   = (cil_q == nrmc_pkg::HDR_LEN) && (hdr_q == nrmc_pkg::HDR_RMC);
    dig      = char_i[3:0];
    acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {30'd0, dig};
    acc_next = (acc_x10 > {4'd0, nrmc_pkg::ACC_CAP}) ? nrmc_pkg::ACC_CAP : acc_x10[29:0];
    deg_x10  = {deg_q, 3'b000} + {2'b00, deg_q, 1'b0} + {9'd0, dig};
    use_deg  = ((fnum_q == nrmc_pkg::FLD_LAT) &&
                (cif_q < 6'(nrmc_pkg::LAT_DEG_DIGITS))) ||
               ((fnum_q == nrmc_pkg::FLD_LON) &&
                (cif_q < 6'(nrmc_pkg::LON_DEG_DIGITS)));
    use_val  = (fnum_q == nrmc_pkg::FLD_TIME) || (fnum_q == nrmc_pkg::FLD_DATE) ||
               (((fnum_q == nrmc_pkg::FLD_LAT) || (fnum_q == nrmc_pkg::FLD_LON)) && !use_deg);
    use_chr  = (fnum_q == nrmc_pkg::FLD_STATUS) || (fnum_q == nrmc_pkg::FLD_NS) ||
               (fnum_q == nrmc_pkg::FLD_EW);
    if (fnum_q == nrmc_pkg::FLD_TIME) begin
      vmax = 3'(nrmc_pkg::TIME_FRAC_DIGITS);
    end else if (fnum_q == nrmc_pkg::FLD_DATE) begin
      vmax = 3'd0;
    end else begin
      vmax = 3'(nrmc_pkg::MINUTE_FRAC_DIGITS);
    end
  end

  // Next state of the line and field parser
  always_comb begin
    hdr_d    = hdr_q;
    cil_d    = cil_q;
    fnum_d   = fnum_q;
    cif_d    = cif_q;
    acc_d    = acc_q;
    deg_d    = deg_q;
    frac_d   = frac_q;
    vseen_d  = vseen_q;
    vstop_d  = vstop_q;
    infrac_d = infrac_q;
    dseen_d  = dseen_q;
    dstop_d  = dstop_q;
    if (is_eol) begin
      hdr_d    = '0;
      cil_d    = '0;
      fnum_d   = '0;
      cif_d    = '0;
      acc_d    = '0;
      deg_d    = '0;
      frac_d   = '0;
      vseen_d  = 1'b0;
      vstop_d  = 1'b0;
      infrac_d = 1'b0;
      dseen_d  = 1'b0;
      dstop_d  = 1'b0;
    end else begin
      // Shift the byte into the header until six are held
      if (cil_q < nrmc_pkg::HDR_LEN) begin
        hdr_d = {hdr_q[39:0], char_i};
        cil_d = cil_q + 3'd1;
      end
      if (is_comma) begin
        // Close the field and start the next one
        if (fnum_q != nrmc_pkg::FLD_LAST) begin
          fnum_d = fnum_q + 5'd1;
        end
        cif_d    = '0;
        acc_d    = '0;
        deg_d    = '0;
        frac_d   = '0;
        vseen_d  = 1'b0;
        vstop_d  = 1'b0;
        infrac_d = 1'b0;
        dseen_d  = 1'b0;
        dstop_d  = 1'b0;
      end else begin
        if (cif_q < 6'(nrmc_pkg::FIELD_CHARS - 1)) begin
          // Value part: integer digits, one dot, truncated fraction digits
          if (use_val && !vstop_q) begin
            if (is_digit) begin
              if (!infrac_q) begin
                acc_d = acc_next;
              end else if (frac_q < vmax) begin
                acc_d  = acc_next;
                frac_d = frac_q + 3'd1;
              end
              vseen_d = 1'b1;
            end else if ((char_i == nrmc_pkg::CH_DOT) && !infrac_q && (vmax != 3'd0)) begin
              infrac_d = 1'b1;
            end else begin
              vstop_d = 1'b1;
            end
          end
          // Degree part of a position field
          if (use_deg && !dstop_q) begin
            if (is_digit) begin
              deg_d   = deg_x10[9:0];
              dseen_d = 1'b1;
            end else begin
              dstop_d = 1'b1;
            end
          end
          // Letter fields keep their first byte
          if (use_chr && (cif_q == 6'd0)) begin
            acc_d = {22'd0, char_i};
          end
        end
        if (cif_q != 6'h3F) begin
          cif_d = cif_q + 6'd1;
        end
      end
    end
  end

  // Hand the closed field to the commit pipeline
  always_comb begin
    tok_valid_o    = accept_i && (is_eol || (is_comma && is_rmc));
    tok_o.fnum     = fnum_q;
    tok_o.acc      = acc_q;
    tok_o.deg      = deg_q;
    tok_o.frac     = frac_q;
    tok_o.val_seen = vseen_q;
    tok_o.deg_seen = dseen_q;
    tok_o.commit   = is_rmc;
    tok_o.eol      = is_eol;
    tok_o.kind     = nrmc_pkg::kind_of(hdr_q, cil_q);
  end

  // Advance the parser on every accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q    <= '0;
      cil_q    <= '0;
      fnum_q   <= '0;
      cif_q    <= '0;
      acc_q    <= '0;
      deg_q    <= '0;
      frac_q   <= '0;
      vseen_q  <= 1'b0;
      vstop_q  <= 1'b0;
      infrac_q <= 1'b0;
      dseen_q  <= 1'b0;
      dstop_q  <= 1'b0;
    end else if (accept_i) begin
      hdr_q    <= hdr_d;
      cil_q    <= cil_d;
      fnum_q   <= fnum_d;
      cif_q    <= cif_d;
      acc_q    <= acc_d;
      deg_q    <= deg_d;
      frac_q   <= frac_d;
      vseen_q  <= vseen_d;
      vstop_q  <= vstop_d;
      infrac_q <= infrac_d;
      dseen_q  <= dseen_d;
      dstop_q  <= dstop_d;
    end
  end

endmodule

>>> design/nrmc_commit.sv
// Commit pipeline: scales closed RMC fields, updates the stored fix values and
// holds the result register. Depends on nrmc_pkg.
module nrmc_commit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  input  nrmc_pkg::token_t tok_i,
  output logic             tok_ready_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [2:0]       res_kind_o,
  output logic             res_fix_o,
  output logic [26:0]      res_time_o,
  output logic [29:0]      res_lat_o,
  output logic             res_south_o,
  output logic [33:0]      res_lon_o,
  output logic             res_west_o,
  output logic [19:0]      res_date_o
);

  // Stage valids and handshake
  logic v1_q, v2_q, v3_q, o_valid_q;
  logic o_free, adv3, rdy1, rdy2, rdy3;

  nrmc_pkg::token_t tok1_q, tok2_q, tok3_q;

  // Stage 1: divide the minutes accumulator by three, scale degrees
  logic [61:0] recip_prod;
  logic [28:0] q3;
  logic [29:0] q3x3;
  logic [1:0]  r3;
  logic [33:0] dege7_s1;
  logic [28:0] q_q;
  logic [1:0]  r_q;
  logic [33:0] dege7_q, dege7_s2_q;

  // Stage 2: the one general product
  logic [29:0] mul_a;
  logic [18:0] mul_b;
  logic [48:0] prod_d, prod_q;
  logic [18:0] rterm_d, rterm_q;

  // Stage 3: final values and the stored fix
  logic [48:0] pos;
  logic [26:0] time_v;
  logic [29:0] lat_v;
  logic [33:0] lon_v;
  logic [19:0] date_v;

  logic        st_fix_q, st_fix_d;
  logic        st_south_q, st_south_d;
  logic        st_west_q, st_west_d;
  logic [26:0] st_time_q, st_time_d;
  logic [29:0] st_lat_q, st_lat_d;
  logic [33:0] st_lon_q, st_lon_d;
  logic [19:0] st_date_q, st_date_d;

  logic [2:0]  o_kind_q;
  logic        o_fix_q, o_south_q, o_west_q;
  logic [26:0] o_time_q;
  logic [29:0] o_lat_q;
  logic [33:0] o_lon_q;
  logic [19:0] o_date_q;

  // Stall only when a line end meets a full result register
  always_comb begin
    o_free      = !o_valid_q || res_ready_i;
    adv3        = v3_q && (!tok3_q.eol || o_free);
    rdy3        = !v3_q || adv3;
    rdy2        = !v2_q || rdy3;
    rdy1        = !v1_q || rdy2;
    tok_ready_o = rdy1;
  end

  // Stage 1 arithmetic
  always_comb begin
    recip_prod = 62'(tok1_q.acc) * 62'(nrmc_pkg::RECIP3);
    q3         = recip_prod[61:33];
    q3x3       = {q3, 1'b0} + {1'b0, q3};
    r3         = 2'(tok1_q.acc - q3x3);
    dege7_s1   = 34'(tok1_q.deg) * 34'(nrmc_pkg::DEG_SCALE);
  end

  // Stage 2 arithmetic: time uses the raw value, positions the quotient
  always_comb begin
    if (tok2_q.fnum == nrmc_pkg::FLD_TIME) begin
      mul_a = tok2_q.acc;
      mul_b = nrmc_pkg::time_scale(tok2_q.frac);
    end else begin
      mul_a = {1'b0, q_q};
      mul_b = nrmc_pkg::pos_scale(tok2_q.frac);
    end
    prod_d  = 49'(mul_a) * 49'(mul_b);
    rterm_d = nrmc_pkg::pos_rem(r_q, tok2_q.frac);
  end

  // Stage 3: saturate and update the stored fix values
  always_comb begin
    pos    = prod_q + {30'd0, rterm_q} + {15'd0, dege7_s2_q};
    time_v = (prod_q > nrmc_pkg::TIME_MAX) ? 27'(nrmc_pkg::TIME_MAX) : prod_q[26:0];
    lat_v  = (pos > nrmc_pkg::LAT_MAX) ? 30'(nrmc_pkg::LAT_MAX) : pos[29:0];
    lon_v  = (pos > nrmc_pkg::LON_MAX) ? 34'(nrmc_pkg::LON_MAX) : pos[33:0];
    date_v = (tok3_q.acc > nrmc_pkg::DATE_MAX) ? 20'(nrmc_pkg::DATE_MAX) : tok3_q.acc[19:0];

    st_fix_d   = st_fix_q;
    st_south_d = st_south_q;
    st_west_d  = st_west_q;
    st_time_d  = st_time_q;
    st_lat_d   = st_lat_q;
    st_lon_d   = st_lon_q;
    st_date_d  = st_date_q;
    if (adv3 && tok3_q.commit) begin
      unique case (tok3_q.fnum)
        nrmc_pkg::FLD_TIME: begin
          if (tok3_q.val_seen) st_time_d = time_v;
        end
        nrmc_pkg::FLD_STATUS: begin
          if (tok3_q.acc == 30'(nrmc_pkg::CH_A)) st_fix_d = 1'b1;
          else if (tok3_q.acc == 30'(nrmc_pkg::CH_V)) st_fix_d = 1'b0;
        end
        nrmc_pkg::FLD_LAT: begin
          if (tok3_q.val_seen && tok3_q.deg_seen) st_lat_d = lat_v;
        end
        nrmc_pkg::FLD_NS: begin
          if (tok3_q.acc == 30'(nrmc_pkg::CH_N)) st_south_d = 1'b0;
          else if (tok3_q.acc == 30'(nrmc_pkg::CH_S)) st_south_d = 1'b1;
        end
        nrmc_pkg::FLD_LON: begin
          if (tok3_q.val_seen && tok3_q.deg_seen) st_lon_d = lon_v;
        end
        nrmc_pkg::FLD_EW: begin
          if (tok3_q.acc == 30'(nrmc_pkg::CH_E)) st_west_d = 1'b0;
          else if (tok3_q.acc == 30'(nrmc_pkg::CH_W)) st_west_d = 1'b1;
        end
        nrmc_pkg::FLD_DATE: begin
          if (tok3_q.val_seen) st_date_d = date_v;
        end
        default: ;
      endcase
    end
  end

  // Control: stage valids, result valid and the stored fix values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      o_valid_q  <= 1'b0;
      st_fix_q   <= 1'b0;
      st_south_q <= 1'b0;
      st_west_q  <= 1'b0;
      st_time_q  <= '0;
      st_lat_q   <= '0;
      st_lon_q   <= '0;
      st_date_q  <= '0;
    end else begin
      if (rdy1) v1_q <= tok_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (adv3 && tok3_q.eol) begin
        o_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        o_valid_q <= 1'b0;
      end
      st_fix_q   <= st_fix_d;
      st_south_q <= st_south_d;
      st_west_q  <= st_west_d;
      st_time_q  <= st_time_d;
      st_lat_q   <= st_lat_d;
      st_lon_q   <= st_lon_d;
      st_date_q  <= st_date_d;
    end
  end

  // Payload: advance the stages, load the result at a line end
  always_ff @(posedge clk_i) begin
    if (rdy1 && tok_valid_i) begin
      tok1_q <= tok_i;
    end
    if (rdy2 && v1_q) begin
      tok2_q  <= tok1_q;
      q_q     <= q3;
      r_q     <= r3;
      dege7_q <= dege7_s1;
    end
    if (rdy3 && v2_q) begin
      tok3_q     <= tok2_q;
      prod_q     <= prod_d;
      rterm_q    <= rterm_d;
      dege7_s2_q <= dege7_q;
    end
    if (adv3 && tok3_q.eol) begin
      o_kind_q  <= tok3_q.kind;
      o_fix_q   <= st_fix_d;
      o_time_q  <= st_time_d;
      o_lat_q   <= st_lat_d;
      o_south_q <= st_south_d;
      o_lon_q   <= st_lon_d;
      o_west_q  <= st_west_d;
      o_date_q  <= st_date_d;
    end
  end

  assign res_valid_o = o_valid_q;
  assign res_kind_o  = o_kind_q;
  assign res_fix_o   = o_fix_q;
  assign res_time_o  = o_time_q;
  assign res_lat_o   = o_lat_q;
  assign res_south_o = o_south_q;
  assign res_lon_o   = o_lon_q;
  assign res_west_o  = o_west_q;
  assign res_date_o  = o_date_q;

endmodule

>>> design/nmea_rmc_sentence_parser_top.sv
// NMEA RMC sentence parser: one byte per cycle; a line end byte yields its result
// through commit stages 1 to 3, then the result register.
// One byte every cycle, but the input stalls when a line end meets a full result register.
// Reset (rst_ni low, asynchronous) clears the parser, the pipeline valids and
// the stored fix values (time, date, position zero, north, east, void).
// Depends on nrmc_pkg, nrmc_parse, nrmc_commit and the assertion macro header.
`include "nmea_rmc_sentence_parser_top_assert.svh"

module nmea_rmc_sentence_parser_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] in_char
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [0] fix_active, [27:1] utc_time, [57:28] latitude_e7, [58] lat_is_south,
  // [92:59] longitude_e7, [93] lon_west, [113:94] date_ddmmyy, [119:114] zero
  output logic [119:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o    // [2:0] sentence_kind
);

  logic             accept;
  logic             tok_valid;
  nrmc_pkg::token_t tok;

  logic        res_fix, res_south, res_west;
  logic [26:0] res_time;
  logic [29:0] res_lat;
  logic [33:0] res_lon;
  logic [19:0] res_date;
  logic        res_in_range;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  nrmc_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_i      (s_axis_tdata_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok)
  );

  nrmc_commit u_commit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_ready_o (s_axis_tready_o),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_kind_o  (m_axis_tuser_o),
    .res_fix_o   (res_fix),
    .res_time_o  (res_time),
    .res_lat_o   (res_lat),
    .res_south_o (res_south),
    .res_lon_o   (res_lon),
    .res_west_o  (res_west),
    .res_date_o  (res_date)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tdata_o = {6'd0, res_date, res_west, res_lon, res_south, res_lat,
                           res_time, res_fix};

  // Range check of the result values
  assign res_in_range = (res_time <= 27'(nrmc_pkg::TIME_MAX)) &&
                        (res_lat <= 30'(nrmc_pkg::LAT_MAX)) &&
                        (res_lon <= 34'(nrmc_pkg::LON_MAX)) &&
                        (res_date <= 20'(nrmc_pkg::DATE_MAX));

  // Tokens only come from accepted items
  `NRMC_ASSERT_IMPLY(a_tok_on_accept, clk_i, rst_ni, tok_valid, accept)
  // Comma tokens are raised for RMC lines only
  `NRMC_ASSERT_IMPLY(a_comma_tok_rmc, clk_i, rst_ni, tok_valid && !tok.eol, tok.commit)
  // Result values stay within their ranges
  `NRMC_ASSERT_IMPLY(a_res_range, clk_i, rst_ni, m_axis_tvalid_o, res_in_range)
  // Padding bits of the result stay zero
  `NRMC_ASSERT_ALWAYS(a_pad_zero, clk_i, rst_ni, m_axis_tdata_o[119:114] == 6'd0)

endmodule
